[hdl/rme_pkg.sv]
package rme_pkg;

   localparam int unsigned FIELD_BITS = 32;
   localparam int unsigned CSR_INDEX_BITS = 2;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_EXPONENT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MODULUS  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MODE     = 2'd2;

   localparam logic [FIELD_BITS-1:0] EXPONENT_RESET = 32'd1;
   localparam logic [FIELD_BITS-1:0] MODULUS_RESET  = 32'd2;
   localparam logic                  MODE_RESET     = 1'b0;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   localparam logic [7:0] END_NUL     = 8'd0;
   localparam logic [7:0] END_NEWLINE = 8'd10;

   // which modular multiply the shared unit runs
   typedef enum logic [1:0] {
      OP_REDUCE,
      OP_SQUARE,
      OP_MULT
   } op_type;

   typedef struct packed {
      logic   load;
      logic   mul_start;
      logic   mul_step;
      op_type op;
      logic   store;
      logic   exp_shift;
      logic   emit;
      logic   emit_zero;
   } cmd_type;

   typedef struct packed {
      logic short_item;
      logic exp_msb;
   } status_type;

endpackage

[hdl/rme_datapath.sv]
module rme_datapath #(
   parameter int unsigned WORD_BITS = 32
) (
   input  logic                             clock,
   input  rme_pkg::cmd_type                 cmd,
   output rme_pkg::status_type              status,
   input  logic [rme_pkg::FIELD_BITS-1:0]   value,
   input  logic [rme_pkg::FIELD_BITS-1:0]   exponent,
   input  logic [rme_pkg::FIELD_BITS-1:0]   modulus,
   input  logic                             mode,
   output logic [rme_pkg::FIELD_BITS-1:0]   result,
   output logic                             terminator
);
   import rme_pkg::*;

   localparam int unsigned W = WORD_BITS;
   localparam int unsigned CW = (W < FIELD_BITS) ? W : FIELD_BITS;

   logic [W-1:0] value_w;
   logic [W-1:0] exp_w;
   logic [W-1:0] mod_w;
   logic [W-1:0] operand;
   logic [W-1:0] one;
   logic         term_now;
   logic         mod_zero;

   logic [W-1:0] x_ff;
   logic [W-1:0] base_ff;
   logic [W-1:0] acc_ff;
   logic [W-1:0] exp_ff, exp_in;
   logic [W-1:0] prod_ff, prod_in;
   logic [W-1:0] ma_ff;
   logic [W-1:0] mb_ff;
   logic [FIELD_BITS-1:0] result_ff;
   logic                  terminator_ff;

   logic [W:0]   dbl;
   logic [W-1:0] dbl_red;
   logic [W:0]   sum;
   logic [W-1:0] sum_red;

   assign value_w = W'(value[CW-1:0]);
   assign exp_w   = W'(exponent[CW-1:0]);
   assign mod_w   = W'(modulus[CW-1:0]);

   always_comb begin
      if (mode == MODE_ENCRYPT) begin
         operand  = W'(value_w[7:0]);
         term_now = (value_w[7:0] == END_NUL) || (value_w[7:0] == END_NEWLINE);
      end else begin
         operand  = value_w;
         term_now = (value_w == '0);
      end
   end

   assign mod_zero = (mod_w == '0);
   assign one      = (mod_w == W'(1)) ? '0 : W'(1);

   assign status.short_item = term_now || mod_zero;
   assign status.exp_msb    = exp_ff[W-1];

   // one bit of the shift-and-add modular multiply: double, then add if b bit set
   always_comb begin
      dbl     = {prod_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, mod_w}) ? W'(dbl - {1'b0, mod_w}) : dbl[W-1:0];
      sum     = {1'b0, dbl_red} + {1'b0, ma_ff};
      sum_red = (sum >= {1'b0, mod_w}) ? W'(sum - {1'b0, mod_w}) : sum[W-1:0];
      prod_in = mb_ff[W-1] ? sum_red : dbl_red;
   end

   always_comb begin
      exp_in = exp_ff;
      if (cmd.load) begin
         exp_in = exp_w;
      end else if (cmd.exp_shift) begin
         exp_in = {exp_ff[W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      exp_ff <= exp_in;
      if (cmd.load) begin
         x_ff   <= operand;
         acc_ff <= one;
      end
      if (cmd.mul_start) begin
         prod_ff <= '0;
         case (cmd.op)
            OP_REDUCE: begin
               ma_ff <= one;
               mb_ff <= x_ff;
            end
            OP_SQUARE: begin
               ma_ff <= acc_ff;
               mb_ff <= acc_ff;
            end
            OP_MULT: begin
               ma_ff <= acc_ff;
               mb_ff <= base_ff;
            end
            default: begin
               ma_ff <= acc_ff;
               mb_ff <= acc_ff;
            end
         endcase
      end else if (cmd.mul_step) begin
         prod_ff <= prod_in;
         mb_ff   <= {mb_ff[W-2:0], 1'b0};
      end
      if (cmd.store) begin
         if (cmd.op == OP_REDUCE) begin
            base_ff <= prod_ff;
         end else begin
            acc_ff <= prod_ff;
         end
      end
      if (cmd.emit) begin
         if (cmd.emit_zero) begin
            result_ff     <= '0;
            terminator_ff <= term_now;
         end else begin
            result_ff     <= FIELD_BITS'(acc_ff);
            terminator_ff <= 1'b0;
         end
      end
   end

   assign result     = result_ff;
   assign terminator = terminator_ff;

endmodule

[hdl/rme_ctrl.sv]
module rme_ctrl #(
   parameter int unsigned WORD_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   output rme_pkg::cmd_type    cmd,
   input  rme_pkg::status_type status
);
   import rme_pkg::*;

   localparam int unsigned CNT_BITS = $clog2(WORD_BITS);

   typedef enum logic [2:0] {
      IDLE,
      START_MUL,
      RUN,
      POST,
      EMIT
   } state_type;

   state_type           state_ff;
   op_type              op_ff;
   logic [CNT_BITS-1:0] mcnt_ff;
   logic [CNT_BITS-1:0] ecnt_ff;
   logic                rsp_valid_ff;
   logic                accept;
   logic                need_mult;
   logic                advance;

   assign accept    = start && (state_ff == IDLE);
   assign need_mult = (op_ff == OP_SQUARE) && status.exp_msb;
   // done with this exponent bit: move to the next one, or finish
   assign advance   = (state_ff == POST) && (op_ff != OP_REDUCE) && !need_mult;

   always_comb begin
      cmd           = '0;
      cmd.op        = op_ff;
      cmd.load      = accept;
      cmd.mul_start = (state_ff == START_MUL);
      cmd.mul_step  = (state_ff == RUN);
      cmd.store     = (state_ff == POST);
      cmd.exp_shift = advance && (ecnt_ff != '0);
      cmd.emit      = (accept && status.short_item) || (state_ff == EMIT);
      cmd.emit_zero = (state_ff == IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         op_ff        <= OP_REDUCE;
         mcnt_ff      <= '0;
         ecnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            IDLE: begin
               if (start) begin
                  if (status.short_item) begin
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     op_ff    <= OP_REDUCE;
                     state_ff <= START_MUL;
                  end
               end
            end
            START_MUL: begin
               mcnt_ff  <= CNT_BITS'(WORD_BITS - 1);
               state_ff <= RUN;
            end
            RUN: begin
               if (mcnt_ff == '0) begin
                  state_ff <= POST;
               end else begin
                  mcnt_ff <= mcnt_ff - 1'b1;
               end
            end
            POST: begin
               if (op_ff == OP_REDUCE) begin
                  op_ff    <= OP_SQUARE;
                  ecnt_ff  <= CNT_BITS'(WORD_BITS - 1);
                  state_ff <= START_MUL;
               end else if (need_mult) begin
                  op_ff    <= OP_MULT;
                  state_ff <= START_MUL;
               end else if (ecnt_ff == '0) begin
                  state_ff <= EMIT;
               end else begin
                  ecnt_ff  <= ecnt_ff - 1'b1;
                  op_ff    <= OP_SQUARE;
                  state_ff <= START_MUL;
               end
            end
            EMIT: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= IDLE;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_outcome: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff || (state_ff == START_MUL)))
      else $error("accepted item neither answered nor started");

   a_start_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == START_MUL) |=> (state_ff == RUN))
      else $error("multiply start not followed by run");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == RUN) && (mcnt_ff == '0)) |=> (state_ff == POST))
      else $error("multiply did not end after last bit");

   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == IDLE))
      else $error("result strobe while busy");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EMIT) |=> (rsp_valid_ff && !busy))
      else $error("emit did not produce a result");

endmodule

[hdl/rsa_modexp_crypt_stream_unit.sv]
// An item that ends the message (or any item with modulus 0) gives its result in
// the cycle after it is accepted. Otherwise the controller runs the bit-serial
// modular multiplier to reduce the input, then squares once for each of the
// W = WORD_BITS exponent bits, with a multiply after each square whose bit is set.
// One item at a time. The receiver cannot stall: rsp_valid is high for one cycle per item.
// Synchronous reset returns the controller to idle and the CSRs to their reset values.
module rsa_modexp_crypt_stream_unit #(
   parameter int unsigned WORD_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [rme_pkg::FIELD_BITS-1:0]      req_value,
   output logic                                rsp_valid,
   output logic [rme_pkg::FIELD_BITS-1:0]      rsp_result,
   output logic                                rsp_terminator,
   input  logic                                csr_we,
   input  logic [rme_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rme_pkg::FIELD_BITS-1:0]      csr_wdata
);
   import rme_pkg::*;

   logic [FIELD_BITS-1:0] exponent_ff;
   logic [FIELD_BITS-1:0] modulus_ff;
   logic                  mode_ff;
   cmd_type               cmd;
   status_type            status;

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= EXPONENT_RESET;
         modulus_ff  <= MODULUS_RESET;
         mode_ff     <= MODE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_EXPONENT: exponent_ff <= csr_wdata;
            REG_MODULUS:  modulus_ff  <= csr_wdata;
            REG_MODE:     mode_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   rme_ctrl #(
      .WORD_BITS(WORD_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   rme_datapath #(
      .WORD_BITS(WORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .status     (status),
      .value      (req_value),
      .exponent   (exponent_ff),
      .modulus    (modulus_ff),
      .mode       (mode_ff),
      .result     (rsp_result),
      .terminator (rsp_terminator)
   );

endmodule
